// ----- hdl/bhld_pkg.sv -----
// Shared types and constants for the button hold and LED steady detector.
// Used by bhld_step and by the top level.
`timescale 1ns / 1ps
package bhld_pkg;

  localparam int CntW   = 10;
  localparam int PulseW = 8;
  localparam int CfgW   = 10;
  localparam int IdxW   = 2;

  localparam logic [CntW-1:0] ChkA    = 10'd100;
  localparam logic [CntW-1:0] ChkB    = 10'd200;
  localparam logic [CntW-1:0] LedChkB = 10'd293;
  localparam logic [CntW-1:0] LedChkC = 10'd345;
  localparam logic [CntW-1:0] LedChkD = 10'd598;

  localparam logic [CntW-1:0]   HoldReset    = 10'd300;
  localparam logic [PulseW-1:0] PulseReset   = 8'd244;
  localparam logic [CntW-1:0]   ConfirmReset = 10'd612;

  typedef enum logic [IdxW-1:0] {
    REG_BUTTON_HOLD = 2'd0,
    REG_PULSE       = 2'd1,
    REG_LED_CONFIRM = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CntW-1:0]   tick_count;
    logic              button_timing;
    logic              led_timing;
    logic              link_up;
    logic [PulseW-1:0] pulse_left;
  } det_state_t;

  typedef struct packed {
    logic [CntW-1:0]   button_hold_ticks;
    logic [PulseW-1:0] pulse_ticks;
    logic [CntW-1:0]   led_confirm_ticks;
  } det_cfg_t;

  typedef struct packed {
    logic vol_up_n;
    logic vol_down_n;
    logic led_level;
    logic tick;
  } poll_t;

endpackage

// ----- hdl/bhld_step.sv -----
// Next-state logic for one poll: button qualifier, LED qualifier and pulse timer.
// Depends on bhld_pkg.
`timescale 1ns / 1ps
module bhld_step (
  input  bhld_pkg::det_state_t cur,
  input  bhld_pkg::det_cfg_t   cfg,
  input  bhld_pkg::poll_t      poll,
  output bhld_pkg::det_state_t nxt
);
  import bhld_pkg::*;

  always_comb begin
    det_state_t s;
    logic       tk;
    logic       both;
    logic       started;
    s       = cur;
    tk      = poll.tick;
    both    = !poll.vol_up_n && !poll.vol_down_n;
    started = 1'b0;
    if (cur.pulse_left != '0) begin
      if (tk) begin
        s.pulse_left = cur.pulse_left - PulseW'(1);
      end
    end else begin
      if (both && !s.button_timing) begin
        s.tick_count    = '0;
        s.button_timing = 1'b1;
        tk              = 1'b0;
      end
      if (tk && s.button_timing) begin
        tk           = 1'b0;
        s.tick_count = s.tick_count + CntW'(1);
        if (s.tick_count == ChkA && !both) begin
          s.tick_count    = '0;
          s.button_timing = 1'b0;
        end
        if (s.tick_count == ChkB && !both) begin
          s.tick_count    = '0;
          s.button_timing = 1'b0;
        end
        if (s.tick_count >= cfg.button_hold_ticks) begin
          if (both) begin
            s.pulse_left = cfg.pulse_ticks;
            started      = 1'b1;
          end
          s.tick_count    = '0;
          s.button_timing = 1'b0;
        end
      end
      if (!s.button_timing && !started) begin
        if (s.link_up && !poll.led_level) begin
          s.link_up = 1'b0;
        end
        if (poll.led_level && !s.led_timing && !s.link_up) begin
          s.tick_count = '0;
          s.led_timing = 1'b1;
          tk           = 1'b0;
        end
        if (tk && s.led_timing) begin
          s.tick_count = s.tick_count + CntW'(1);
          if (!poll.led_level && (s.tick_count == ChkA || s.tick_count == LedChkB ||
                                  s.tick_count == LedChkC || s.tick_count == LedChkD)) begin
            s.tick_count = '0;
            s.led_timing = 1'b0;
          end
          if (s.tick_count >= cfg.led_confirm_ticks) begin
            s.link_up    = poll.led_level;
            s.tick_count = '0;
            s.led_timing = 1'b0;
          end
        end
      end
    end
    nxt = s;
  end

endmodule

// ----- hdl/button_hold_and_led_steady_detector_core.sv -----
// An input transfer is registered in the poll register, and its result is then registered
// in the result register. One poll per cycle while no held result stalls the output;
// the poll register, the state update and the result register form a single pass.
// Reset (rst, synchronous, active high) empties both stages, clears the
// detector state and loads the default register values.
// Depends on bhld_pkg and bhld_step.
`timescale 1ns / 1ps
module button_hold_and_led_steady_detector_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // vol_up_n, vol_down_n, led_level, tick
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // led_drive, sense_drive_low,
                                                    // button_drive_low
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bhld_pkg::IdxW-1:0]  cfg_index,
  input  logic [bhld_pkg::CfgW-1:0]  cfg_data
);
  import bhld_pkg::*;

  det_state_t state;
  det_state_t state_next;
  det_cfg_t   cfg;
  poll_t      poll;
  logic       in_valid;
  logic       out_valid;
  logic [7:0] out_data;
  logic       advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  bhld_step u_step (
    .cur  (state),
    .cfg  (cfg),
    .poll (poll),
    .nxt  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      poll.vol_up_n   <= s_axis_tdata[0];
      poll.vol_down_n <= s_axis_tdata[1];
      poll.led_level  <= s_axis_tdata[2];
      poll.tick       <= s_axis_tdata[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= {5'b0, (state_next.pulse_left != '0), state_next.link_up,
                   state_next.link_up};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_hold_ticks <= HoldReset;
      cfg.pulse_ticks       <= PulseReset;
      cfg.led_confirm_ticks <= ConfirmReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUTTON_HOLD: cfg.button_hold_ticks <= cfg_data;
        REG_PULSE:       cfg.pulse_ticks       <= cfg_data[PulseW-1:0];
        REG_LED_CONFIRM: cfg.led_confirm_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_timing_in_pulse: assert property (@(posedge clk) disable iff (rst)
    !(state.button_timing && state.pulse_left != '0))
    else $error("button qualifier running during pulse");

  a_link_frozen_in_pulse: assert property (@(posedge clk) disable iff (rst)
    state.pulse_left != '0 |=> $stable(state.link_up))
    else $error("connected state changed during pulse");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled without a held result");
`endif

endmodule

// ----- tb/bhld_checker.sv -----
// Result checker for the button hold and LED steady detector: predicts the drive
// outputs of every accepted poll and compares them with the result transfers.
// Depends on bhld_pkg.
`timescale 1ns / 1ps
module bhld_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [7:0]                m_axis_tdata,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [bhld_pkg::IdxW-1:0] cfg_index,
  input  logic [bhld_pkg::CfgW-1:0] cfg_data,
  output int                        mismatches,
  output int                        drives_pending
);
  import bhld_pkg::*;

  typedef struct packed {
    logic button_drive_low;
    logic sense_drive_low;
    logic led_drive;
  } drive_t;

  det_state_t st;
  det_cfg_t   cfg;
  drive_t     drive_queue[$];

  task automatic advance_detector(input poll_t p, output drive_t d);
    logic both;
    logic started;
    logic tk;
    tk = p.tick;
    both = !p.vol_up_n && !p.vol_down_n;
    started = 1'b0;
    if (st.pulse_left != '0) begin
      if (tk) st.pulse_left = st.pulse_left - PulseW'(1);
    end else begin
      if (both && !st.button_timing) begin
        st.tick_count = '0;
        st.button_timing = 1'b1;
        tk = 1'b0;
      end
      if (tk && st.button_timing) begin
        tk = 1'b0;
        st.tick_count = st.tick_count + CntW'(1);
        if (!both && (st.tick_count == ChkA || st.tick_count == ChkB)) begin
          {st.tick_count, st.button_timing} = '0;
        end
        if (st.tick_count >= cfg.button_hold_ticks) begin
          if (both) begin
            st.pulse_left = cfg.pulse_ticks;
            started = 1'b1;
          end
          {st.tick_count, st.button_timing} = '0;
        end
      end
      // The LED qualifier is frozen while the button qualifier runs.
      if (!st.button_timing && !started) begin
        if (st.link_up && !p.led_level) st.link_up = 1'b0;
        if (p.led_level && !st.led_timing && !st.link_up) begin
          st.tick_count = '0;
          st.led_timing = 1'b1;
          tk = 1'b0;
        end
        if (tk && st.led_timing) begin
          st.tick_count = st.tick_count + CntW'(1);
          if (!p.led_level && (st.tick_count == ChkA || st.tick_count == LedChkB ||
                               st.tick_count == LedChkC || st.tick_count == LedChkD)) begin
            {st.tick_count, st.led_timing} = '0;
          end
          if (st.tick_count >= cfg.led_confirm_ticks) begin
            st.link_up = p.led_level;
            {st.tick_count, st.led_timing} = '0;
          end
        end
      end
    end
    d.led_drive = st.link_up;
    d.sense_drive_low = st.link_up;
    d.button_drive_low = (st.pulse_left != '0);
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s expected %b got %b", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    poll_t  p;
    drive_t want;
    drive_t got;
    if (rst) begin
      st = '0;
      cfg = '{button_hold_ticks: HoldReset, pulse_ticks: PulseReset,
              led_confirm_ticks: ConfirmReset};
      drive_queue.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_BUTTON_HOLD: cfg.button_hold_ticks = cfg_data;
          REG_PULSE:       cfg.pulse_ticks = cfg_data[PulseW-1:0];
          REG_LED_CONFIRM: cfg.led_confirm_ticks = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        p.vol_up_n = s_axis_tdata[0];
        p.vol_down_n = s_axis_tdata[1];
        p.led_level = s_axis_tdata[2];
        p.tick = s_axis_tdata[3];
        advance_detector(p, want);
        drive_queue.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = drive_t'(m_axis_tdata[2:0]);
        if (drive_queue.size() == 0) begin
          $display("%0t: result expected nothing got %b", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = drive_queue.pop_front();
          check_field("led_drive", want.led_drive, got.led_drive);
          check_field("sense_drive_low", want.sense_drive_low, got.sense_drive_low);
          check_field("button_drive_low", want.button_drive_low, got.button_drive_low);
        end
      end
    end
    drives_pending = drive_queue.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the detector testbench: clock, reset, poll stimulus, register writes
// and the final verdict. Depends on bhld_pkg, bhld_checker and the detector core.
`timescale 1ns / 1ps
module tb;
  import bhld_pkg::*;

  localparam int CycleLimit = 600000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [IdxW-1:0] cfg_index = REG_BUTTON_HOLD;
  logic [CfgW-1:0] cfg_data = '0;

  int mismatches;
  int drives_pending;
  int cycles = 0;
  int polls_sent = 0;
  int results_seen = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  int hold_set = int'(HoldReset);
  int pulse_set = int'(PulseReset);
  int confirm_set = int'(ConfirmReset);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_hold_and_led_steady_detector_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bhld_checker drive_check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .drives_pending(drives_pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_poll(input poll_t p);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, p.tick, p.led_level, p.vol_down_n, p.vol_up_n};
    do @(posedge clk); while (!s_axis_tready);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (drives_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input int hold, input int pulse, input int confirm);
    reg_idx_t idx[3];
    int       val[3];
    idx = '{REG_BUTTON_HOLD, REG_PULSE, REG_LED_CONFIRM};
    val = '{hold, pulse, confirm};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i][CfgW-1:0];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    hold_set = hold;
    pulse_set = pulse;
    confirm_set = confirm;
  endtask

  // Both buttons held with a tick on every poll long enough to fire the pulse,
  // then polls while it drains. A broken hold releases one button across the
  // checkpoint at 100 or 200 ticks.
  task automatic hold_sequence();
    poll_t p;
    int    len;
    int    cp;
    bit    broken;
    len = hold_set + 4;
    broken = ($urandom_range(0, 2) == 0);
    cp = $urandom_range(0, 1) ? int'(ChkA) : int'(ChkB);
    for (int k = 0; k < len; k++) begin
      p.vol_up_n = 1'b0;
      p.vol_down_n = 1'b0;
      p.led_level = 1'($urandom_range(0, 1));
      p.tick = 1'b1;
      if (broken && k >= cp - 1 && k <= cp + 1) begin
        if ($urandom_range(0, 1)) p.vol_up_n = 1'b1;
        else p.vol_down_n = 1'b1;
      end
      send_poll(p);
    end
    for (int k = 0; k < pulse_set + pulse_set / 8 + 4; k++) begin
      p = poll_t'(4'($urandom_range(0, 15)));
      p.tick = ($urandom_range(0, 7) != 0);
      send_poll(p);
    end
  endtask

  // LED lit with a tick on every poll long enough to be confirmed, without both
  // buttons pressed. A broken run darkens the LED around one of the checkpoints
  // or the confirm count.
  task automatic led_sequence();
    poll_t       p;
    int          len;
    int          cp;
    bit          broken;
    logic [1:0]  btn;
    len = confirm_set + 4;
    broken = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 4))
      0: cp = int'(ChkA);
      1: cp = int'(LedChkB);
      2: cp = int'(LedChkC);
      3: cp = int'(LedChkD);
      default: cp = confirm_set;
    endcase
    for (int k = 0; k < len; k++) begin
      btn = 2'($urandom_range(1, 3));
      p.vol_up_n = btn[0];
      p.vol_down_n = btn[1];
      p.led_level = !(broken && k >= cp - 1 && k <= cp + 1);
      p.tick = 1'b1;
      send_poll(p);
    end
    if ($urandom_range(0, 1)) begin
      for (int k = 0; k < $urandom_range(1, 5); k++) begin
        p = poll_t'(4'($urandom_range(0, 15)));
        p.led_level = 1'b0;
        send_poll(p);
      end
    end
  endtask

  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 7);
      if (results_seen == 300 || results_seen == 1800) stall = 200;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    poll_t p;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    configure(201, 1, 599);
    led_sequence();
    hold_sequence();
    for (int v = 0; v < 16; v++) send_poll(poll_t'(4'(v)));
    p = '{vol_up_n: 1'b0, vol_down_n: 1'b0, led_level: 1'b1, tick: 1'b1};
    repeat (4) send_poll(p);
    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
